// ----- rtl/at_response_pattern_matcher_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef AT_RESPONSE_PATTERN_MATCHER_TOP_MACROS_SVH
`define AT_RESPONSE_PATTERN_MATCHER_TOP_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define ARPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ARPM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/arpm_pkg.sv -----
// ----------------------------------------------------------------------------
// arpm_pkg
// Types, codes and constants of the response pattern matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpm_pkg;

    localparam int RESP_BUF_SIZE = 256;
    localparam int PATTERN_BYTES = 8;

    localparam int PAT_W   = PATTERN_BYTES * 8;
    localparam int CNT_W   = $clog2(RESP_BUF_SIZE);
    localparam int LEN_W   = 4;
    localparam int TICK_W  = 32;
    localparam int REG_W   = 64;
    localparam int IDX_W   = 2;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    // Item modes.
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_AT_ERROR = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    // Register indexes.
    localparam logic [IDX_W-1:0] CFG_IDX_PATTERN = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_LENGTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd2;

    // Reset values of the registers.
    localparam logic [REG_W-1:0]  RST_PATTERN = 64'd20299;
    localparam logic [LEN_W-1:0]  RST_LENGTH  = 4'd2;
    localparam logic [TICK_W-1:0] RST_TIMEOUT = 32'd1000;

    // Fixed error responses, last character in the lowest byte.
    localparam logic [39:0] TXT_ERROR = 40'h4552524F52;
    localparam logic [31:0] TXT_FAIL  = 32'h4641494C;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic       done_res;
    } t_out_word;

    typedef struct packed {
        logic [REG_W-1:0]  pattern;
        logic [LEN_W-1:0]  length;
        logic [TICK_W-1:0] timeout;
    } t_cfg;

endpackage

// ----- rtl/arpm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// arpm_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpm_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [arpm_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [arpm_pkg::REG_W-1:0] i_cfg_data,
    output arpm_pkg::t_cfg            o_cfg
);
    import arpm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= RST_PATTERN;
            r_cfg.length  <= RST_LENGTH;
            r_cfg.timeout <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_PATTERN: r_cfg.pattern <= i_cfg_data;
                CFG_IDX_LENGTH:  r_cfg.length  <= i_cfg_data[LEN_W-1:0];
                CFG_IDX_TIMEOUT: r_cfg.timeout <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/arpm_core.sv -----
// ----------------------------------------------------------------------------
// arpm_core
// Input register, wait state and combinational match of the byte window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  arpm_pkg::t_in_word  i_word,
    input  arpm_pkg::t_cfg      i_cfg,
    output logic                o_busy,
    output logic                o_valid,
    output arpm_pkg::t_out_word o_word
);
    import arpm_pkg::*;

    logic                r_in_valid;
    t_in_word            r_in_word;
    logic [PAT_W-1:0]    r_recent,  n_recent;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [TICK_W-1:0]   r_elapsed, n_elapsed;
    logic                r_waiting, n_waiting;
    logic                r_ended,   n_ended;

    logic [PAT_W-1:0]    win;
    logic [PAT_W-1:0]    pat_mask;
    logic [LEN_W-1:0]    len_c;
    logic [TICK_W-1:0]   tick_inc;
    logic                hit_err;
    logic                hit_ok;
    t_out_word           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_in_word <= i_word;
        end
    end

    // Window and checks for the byte in the input register.
    always_comb begin
        win      = {r_recent[PAT_W-9:0], r_in_word.rx_byte};
        len_c    = (i_cfg.length > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES)
                                                         : i_cfg.length;
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            pat_mask[i*8 +: 8] = {8{LEN_W'(i) < len_c}};
        end
        hit_err  = ((n_count >= CNT_W'(5)) && (win[39:0] == TXT_ERROR)) ||
                   ((n_count >= CNT_W'(4)) && (win[31:0] == TXT_FAIL));
        hit_ok   = (n_count >= CNT_W'(len_c)) &&
                   ((win & pat_mask) == (i_cfg.pattern[PAT_W-1:0] & pat_mask));
        tick_inc = (r_elapsed == {TICK_W{1'b1}}) ? r_elapsed : r_elapsed + 1'b1;
    end

    always_comb begin
        n_recent     = r_recent;
        n_count      = r_count;
        n_elapsed    = r_elapsed;
        n_waiting    = r_waiting;
        n_ended      = r_ended;
        res.status   = ST_PENDING;
        res.done_res = 1'b0;
        if (r_in_valid) begin
            case (r_in_word.mode)
                MODE_START: begin
                    n_recent  = '0;
                    n_count   = '0;
                    n_elapsed = '0;
                    n_ended   = 1'b0;
                    n_waiting = 1'b1;
                end
                MODE_TICK: begin
                    if (r_waiting) begin
                        n_elapsed = tick_inc;
                        if (tick_inc >= i_cfg.timeout) begin
                            res.status   = ST_TIMEOUT;
                            res.done_res = 1'b1;
                        end
                    end
                end
                MODE_BYTE: begin
                    if (r_waiting) begin
                        if (r_elapsed >= i_cfg.timeout) begin
                            res.status   = ST_TIMEOUT;
                            res.done_res = 1'b1;
                        end else if (r_count < CNT_W'(RESP_BUF_SIZE - 1)) begin
                            n_recent = win;
                            n_count  = r_count + 1'b1;
                            n_ended  = r_ended || (r_in_word.rx_byte == 8'd0);
                            if (!n_ended) begin
                                if (hit_err) begin
                                    res.status   = ST_AT_ERROR;
                                    res.done_res = 1'b1;
                                end else if (hit_ok) begin
                                    res.status   = ST_OK;
                                    res.done_res = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (res.done_res) begin
                n_waiting = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent  <= '0;
            r_count   <= '0;
            r_elapsed <= '0;
            r_waiting <= 1'b0;
            r_ended   <= 1'b0;
        end else begin
            r_recent  <= n_recent;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_waiting <= n_waiting;
            r_ended   <= n_ended;
        end
    end

    assign o_busy  = r_in_valid;
    assign o_valid = r_in_valid;
    assign o_word  = res;

endmodule

// ----- rtl/arpm_out_fifo.sv -----
// ----------------------------------------------------------------------------
// arpm_out_fifo
// Three-entry result queue that decouples the receiver's stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpm_out_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  arpm_pkg::t_out_word             i_word,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output arpm_pkg::t_out_word             o_out_word,
    output logic [arpm_pkg::FIFO_LVL_W-1:0] o_level
);
    import arpm_pkg::*;

    t_out_word               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_LVL_W-1:0]   r_level,  n_level;
    logic                    pop;

    always_comb begin
        pop      = (r_level != '0) && !i_out_stall;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_level = r_level + FIFO_LVL_W'(i_push) - FIFO_LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_out_valid = (r_level != '0);
    assign o_out_word  = r_mem[r_rd_ptr];
    assign o_level     = r_level;

endmodule

// ----- rtl/at_response_pattern_matcher_top.sv -----
// ----------------------------------------------------------------------------
// at_response_pattern_matcher_top
// Watches a received modem byte stream for an expected response.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word): each word is a
//   received byte, a millisecond tick or a start of a new wait. Output
//   channel (o_out_valid / i_out_stall / o_out_word): exactly one result
//   word per input word, in order: status and a done flag that marks the
//   word that ended the wait (ok, at_error or timeout).
//   Configuration: i_cfg_we writes i_cfg_data to the register chosen by
//   i_cfg_index (pattern, length, timeout); write only while idle.
//   Result path: each result passes from the input register into the
//   result queue, which presents it once earlier results are taken.
//   Throughput: one word per cycle unless the receiver stalls, set by the
//   combinational window compare between input register and result queue.
//   Stall: results wait in a three-entry queue; o_in_stall rises once the
//   queued results plus the word in the core reach three, so input keeps
//   flowing for up to three words after the receiver holds off.
//   Reset (i_rst_n low, synchronous): drop all queued results, close any
//   wait and restore the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module at_response_pattern_matcher_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input words
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  arpm_pkg::t_in_word         i_in_word,
    // result words
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output arpm_pkg::t_out_word        o_out_word,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic [arpm_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [arpm_pkg::REG_W-1:0] i_cfg_data
);
    import arpm_pkg::*;

    t_cfg                  cfg;
    logic                  in_accept;
    logic                  core_busy;
    logic                  core_valid;
    t_out_word             core_word;
    logic [FIFO_LVL_W-1:0] fifo_level;
    logic [FIFO_LVL_W:0]   in_flight;

    // Hold input while queued results plus the word in the core could fill
    // the queue; both terms are registered, so no path from i_out_stall.
    assign in_flight  = {1'b0, fifo_level} + (FIFO_LVL_W + 1)'(core_busy);
    assign o_in_stall = (in_flight >= (FIFO_LVL_W + 1)'(FIFO_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;

    arpm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Register the word, update the wait state, evaluate the match.
    arpm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept),
        .i_word  (i_in_word),
        .i_cfg   (cfg),
        .o_busy  (core_busy),
        .o_valid (core_valid),
        .o_word  (core_word)
    );

    // Queue results until the receiver takes them.
    arpm_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (core_valid),
        .i_word      (core_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_level     (fifo_level)
    );

endmodule

// ----- rtl/arpm_checker.sv -----
// ----------------------------------------------------------------------------
// arpm_checker
// Port-level checks of the response pattern matcher, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "at_response_pattern_matcher_top_macros.svh"

module arpm_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  arpm_pkg::t_out_word o_out_word
);
    import arpm_pkg::*;

    // Reset empties the result queue.
    `ARPM_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A stalled result stays and holds its value.
    `ARPM_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word), "stalled result changed")

    // A result that does not end the wait carries the pending status.
    `ARPM_ASSERT(a_pending_status, o_out_valid && !o_out_word.done_res |-> o_out_word.status == ST_PENDING, "status without done")

    // A result that ends the wait carries a final status.
    `ARPM_ASSERT(a_done_status, o_out_valid && o_out_word.done_res |-> o_out_word.status != ST_PENDING, "done without final status")

endmodule

bind at_response_pattern_matcher_top arpm_checker u_arpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ----- dv/tb_at_response_pattern_matcher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_at_response_pattern_matcher_top
// Self-checking bench for the modem response pattern matcher.
//
// Offers start, byte, tick and unused-mode words through the valid/stall
// input channel and takes result words through the output channel. Both
// sides idle at random. A built-in model of the matcher predicts each
// result, and every result is checked in order against that prediction.
// Registers are reprogrammed between phases, while the block is idle.
// ----------------------------------------------------------------------------

module tb_at_response_pattern_matcher_top;

    import arpm_pkg::*;

    // Mode code the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int unsigned RESET_CYCLES    = 7;
    localparam int unsigned GAP_MAX         = 12;
    localparam int unsigned ITEM_GOAL       = 850;
    localparam int unsigned PHASE_ITEMS     = 70;
    localparam int unsigned MIN_PHASES      = 7;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned HOLD_OFF_AFTER  = 150;
    localparam int unsigned HOLD_OFF_CYCLES = 120;
    localparam int unsigned IDLE_LIMIT      = 2000;

    // "CONNECT" plus a line feed, last character in the lowest byte.
    localparam logic [REG_W-1:0] TXT_CONNECT = 64'h434F_4E4E_4543_540A;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the matcher's state word by word and holds the
    // results still owed by the block.
    // ------------------------------------------------------------------------
    class status_scoreboard;
        logic [REG_W-1:0]  pattern;
        logic [LEN_W-1:0]  length;
        logic [TICK_W-1:0] timeout;

        logic [PAT_W-1:0]  window;
        int unsigned       stored;
        logic [TICK_W-1:0] elapsed;
        bit                waiting;
        bit                text_ended;

        t_out_word         pending_status[$];
        int unsigned       errors;
        int unsigned       checked;

        function new();
            pattern    = RST_PATTERN;
            length     = RST_LENGTH;
            timeout    = RST_TIMEOUT;
            window     = '0;
            stored     = 0;
            elapsed    = '0;
            waiting    = 1'b0;
            text_ended = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
            case (idx)
                CFG_IDX_PATTERN: pattern = data;
                CFG_IDX_LENGTH:  length  = data[LEN_W-1:0];
                CFG_IDX_TIMEOUT: timeout = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        // True when the newest n stored bytes equal the low n bytes of txt.
        function bit tail_matches(logic [PAT_W-1:0] txt, int unsigned n);
            logic [PAT_W-1:0] mask;
            mask = '1;
            if (n < PATTERN_BYTES)
                mask = (PAT_W'(1) << (n * 8)) - PAT_W'(1);
            return (stored >= n) && ((window & mask) == (txt & mask));
        endfunction

        // Advance the tracked state by one accepted word; queue its result.
        function void note_word(t_in_word w);
            t_out_word   res;
            int unsigned n;
            res = '0;
            n   = (length > PATTERN_BYTES) ? PATTERN_BYTES : length;
            case (w.mode)
                MODE_START: begin
                    window     = '0;
                    stored     = 0;
                    elapsed    = '0;
                    text_ended = 1'b0;
                    waiting    = 1'b1;
                end
                MODE_TICK: begin
                    if (waiting) begin
                        if (elapsed != '1)
                            elapsed++;
                        if (elapsed >= timeout) begin
                            res.status   = ST_TIMEOUT;
                            res.done_res = 1'b1;
                        end
                    end
                end
                MODE_BYTE: begin
                    if (waiting) begin
                        if (elapsed >= timeout) begin
                            res.status   = ST_TIMEOUT;
                            res.done_res = 1'b1;
                        end else if (stored < RESP_BUF_SIZE - 1) begin
                            window = {window[PAT_W-9:0], w.rx_byte};
                            stored++;
                            if (w.rx_byte == 8'h00)
                                text_ended = 1'b1;
                            if (!text_ended) begin
                                if (tail_matches(PAT_W'(TXT_ERROR), 5) ||
                                    tail_matches(PAT_W'(TXT_FAIL), 4)) begin
                                    res.status   = ST_AT_ERROR;
                                    res.done_res = 1'b1;
                                end else if (tail_matches(pattern, n)) begin
                                    res.status   = ST_OK;
                                    res.done_res = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (res.done_res)
                waiting = 1'b0;
            pending_status.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            checked++;
            if (pending_status.size() == 0) begin
                report($sformatf("result with none owed: status %0d done %0b",
                                 got.status, got.done_res));
                return;
            end
            want = pending_status.pop_front();
            if (got.status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            if (got.done_res !== want.done_res)
                report($sformatf("result %0d done %0b, want %0b",
                                 checked, got.done_res, want.done_res));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_word          in_word   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_word         out_word;
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [REG_W-1:0]  cfg_data  = '0;

    status_scoreboard  sb;

    // Largest idle gap each side may draw per word; zero gives a stretch
    // with no idling at all.
    int unsigned       sender_gap_max   = GAP_MAX;
    int unsigned       receiver_gap_max = GAP_MAX;

    // Start words plus words accepted while a wait is open (idle words excluded).
    int unsigned       live_items = 0;
    int unsigned       idle_cycles = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    at_response_pattern_matcher_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Input side. All drives happen right after a rising edge, so the block
    // sees them at the next edge; sampling right after the edge reads the
    // values the block saw at that edge.
    // ------------------------------------------------------------------------

    // Offer one word after a random gap and hold it until it is taken.
    // Valid stays high on return so a back-to-back word needs no toggle.
    task automatic send_word(input logic [1:0] mode, input logic [7:0] rx);
        t_in_word    w;
        int unsigned gap;
        w.mode    = mode;
        w.rx_byte = rx;
        gap = $urandom_range(0, sender_gap_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall !== 1'b0);
        if (mode == MODE_START || sb.waiting)
            live_items++;
        sb.note_word(w);
    endtask

    // Send the low n bytes of txt, highest byte first.
    task automatic send_text(input logic [REG_W-1:0] txt, input int unsigned n);
        for (int i = int'(n) - 1; i >= 0; i--)
            send_word(MODE_BYTE, txt[i*8 +: 8]);
    endtask

    // Drive one register write; the caller drops the write enable.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_register(idx, data);
        @(posedge clk);
    endtask

    // Drain all owed results, let the pipeline settle, then write all three
    // registers back to back.
    task automatic program_settings(input logic [REG_W-1:0]  pat,
                                    input logic [LEN_W-1:0]  len,
                                    input logic [TICK_W-1:0] tmo);
        in_valid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_IDX_PATTERN, pat);
        write_reg(CFG_IDX_LENGTH, REG_W'(len));
        write_reg(CFG_IDX_TIMEOUT, REG_W'(tmo));
        cfg_we <= 1'b0;
    endtask

    // Eight printable characters, or now and then any 64-bit value.
    function automatic logic [REG_W-1:0] random_text();
        logic [REG_W-1:0] txt;
        if ($urandom_range(0, 3) == 0)
            return {$urandom, $urandom};
        for (int i = 0; i < PATTERN_BYTES; i++)
            txt[i*8 +: 8] = 8'($urandom_range(8'h20, 8'h7E));
        return txt;
    endfunction

    // One response: open a wait, then mix pattern text, error words, filler,
    // ticks, zero bytes and noise until the wait closes or segments run out.
    task automatic run_wait();
        int unsigned n;
        int unsigned k;
        int unsigned seg;
        n = (sb.length > PATTERN_BYTES) ? PATTERN_BYTES : sb.length;
        send_word(MODE_START, 8'($urandom_range(0, 255)));
        for (seg = 0; seg < 10 && sb.waiting; seg++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: begin
                    if (n == 0)
                        send_word(MODE_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
                    else
                        send_text(sb.pattern, n);
                end
                4: begin
                    // leading part of the pattern only
                    if (n >= 2) begin
                        k = $urandom_range(1, n - 1);
                        send_text(sb.pattern >> ((n - k) * 8), k);
                    end
                end
                5: send_text(REG_W'(TXT_ERROR), 5);
                6: send_text(REG_W'(TXT_FAIL), 4);
                7, 8, 9: begin
                    repeat ($urandom_range(1, 6))
                        send_word(MODE_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
                end
                10, 11: begin
                    repeat ($urandom_range(1, 4))
                        send_word(MODE_TICK, 8'($urandom_range(0, 255)));
                end
                12: send_word(MODE_BYTE, 8'h00);
                13, 14: begin
                    repeat ($urandom_range(1, 4))
                        send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        send_word(MODE_BYTE, 8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        int unsigned goal;
        sb = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset settings ("OK", length 2, 1000 ticks).
        send_word(MODE_BYTE, 8'h41);                 // idle: ignored
        send_word(MODE_UNUSED, 8'($urandom_range(0, 255)));
        send_word(MODE_START, 8'h00);
        send_text(RST_PATTERN, 2);                   // ok
        send_word(MODE_START, 8'hFF);
        send_text(REG_W'(TXT_ERROR), 5);             // at_error
        send_word(MODE_START, 8'h00);
        send_text(REG_W'(TXT_FAIL) >> 16, 2);        // "FA", then restart
        send_word(MODE_START, 8'h00);
        send_text(REG_W'(TXT_FAIL), 4);              // at_error
        send_word(MODE_START, 8'h00);
        send_word(MODE_BYTE, 8'h00);                 // zero ends visible text
        send_text(RST_PATTERN, 2);                   // must not match

        // Empty pattern and zero timeout: any byte or tick times out.
        program_settings('1, 4'd0, 32'd0);
        send_word(MODE_START, 8'h00);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_START, 8'h00);
        send_word(MODE_TICK, 8'h00);

        // Random phases, each on its own register settings and idling mix.
        for (phase = 0; phase < MIN_PHASES || live_items < ITEM_GOAL; phase++) begin
            case (phase)
                0: program_settings(RST_PATTERN, RST_LENGTH, RST_TIMEOUT);
                1: program_settings(TXT_CONNECT, 4'd8, '1);
                2: program_settings(random_text(), 4'd1, 32'd1);
                3: program_settings('0, 4'hF, 32'd40);
                default: program_settings(random_text(), LEN_W'($urandom_range(0, 15)),
                                          ($urandom_range(0, 3) == 0) ? $urandom
                                                                      : $urandom_range(0, 30));
            endcase
            sender_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            receiver_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;

            if (phase == 0) begin
                // Fill the buffer with lowercase filler that cannot match,
                // then offer the pattern and an error word: both are dropped.
                send_word(MODE_START, 8'h00);
                repeat (RESP_BUF_SIZE - 1)
                    send_word(MODE_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
                send_text(sb.pattern, 2);
                send_text(REG_W'(TXT_ERROR), 5);
            end

            goal = live_items + PHASE_ITEMS;
            while (live_items < goal)
                run_wait();
        end

        // Drain, then give the pipeline time to show any stray result.
        in_valid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_at_response_pattern_matcher_top: clean");
        else
            $display("tb_at_response_pattern_matcher_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: stall a random number of cycles per word, then take the
    // next result and check it. Once, hold off for a long stretch while the
    // sender keeps offering, so the result queue fills and the input stalls.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap;
        bit          held_off;
        held_off = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            gap = $urandom_range(0, receiver_gap_max);
            if (!held_off && sb.checked >= HOLD_OFF_AFTER &&
                sb.pending_status.size() != 0) begin
                held_off = 1'b1;
                gap      = HOLD_OFF_CYCLES;
            end
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_word(out_word);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no word moves on either channel for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_at_response_pattern_matcher_top: errors");
            $finish;
        end
    end

endmodule
